@@ design/bbc_pkg.sv @@
`timescale 1ns / 1ps

package bbc_pkg;

    typedef logic [2:0] status_t;
    typedef logic [1:0] kind_t;

    localparam status_t ST_BALANCED    = 3'd0;
    localparam status_t ST_MISS_OPEN   = 3'd1;
    localparam status_t ST_WRONG_CLOSE = 3'd2;
    localparam status_t ST_MISS_CLOSE  = 3'd3;
    localparam status_t ST_OVERFLOW    = 3'd4;

    localparam kind_t KIND_PAREN  = 2'd0;
    localparam kind_t KIND_BRACE  = 2'd1;
    localparam kind_t KIND_SQUARE = 2'd2;
    localparam kind_t KIND_ANGLE  = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_PAREN_L   = 8'h28;
    localparam logic [7:0] CH_PAREN_R   = 8'h29;
    localparam logic [7:0] CH_BRACE_L   = 8'h7B;
    localparam logic [7:0] CH_BRACE_R   = 8'h7D;
    localparam logic [7:0] CH_SQUARE_L  = 8'h5B;
    localparam logic [7:0] CH_SQUARE_R  = 8'h5D;
    localparam logic [7:0] CH_ANGLE_L   = 8'h3C;
    localparam logic [7:0] CH_ANGLE_R   = 8'h3E;

    localparam int         POS_W   = 9;
    localparam logic [8:0] POS_CAP = 9'd511;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } bracket_t;

    function automatic bracket_t opener_decode(logic [7:0] c);
        bracket_t r;
        r.hit  = 1'b1;
        r.kind = KIND_PAREN;
        case (c)
            CH_PAREN_L:  r.kind = KIND_PAREN;
            CH_BRACE_L:  r.kind = KIND_BRACE;
            CH_SQUARE_L: r.kind = KIND_SQUARE;
            CH_ANGLE_L:  r.kind = KIND_ANGLE;
            default:     r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic bracket_t closer_decode(logic [7:0] c);
        bracket_t r;
        r.hit  = 1'b1;
        r.kind = KIND_PAREN;
        case (c)
            CH_PAREN_R:  r.kind = KIND_PAREN;
            CH_BRACE_R:  r.kind = KIND_BRACE;
            CH_SQUARE_R: r.kind = KIND_SQUARE;
            CH_ANGLE_R:  r.kind = KIND_ANGLE;
            default:     r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ design/bracket_balance_checker.sv @@
`timescale 1ns / 1ps
//  channel   handshake                  payload
//  char      char_valid / char_stall     char_code[7:0]
//  verdict   verdict_valid / verdict_stall  status[2:0] position[8:0] bracket_kind[1:0]
//
//  One byte per cycle while no newline waits on a stalled verdict; a verdict
//  leaves through the input register, then the result register.
//  Top of stack lives in a register; the RAM keeps the entry below it read out
//  every cycle, so a pop does not wait on a RAM read.
//  Reset clears the control state; stack RAM contents are never cleared.
//  Only a newline waits on a stalled verdict register; other bytes keep flowing.

module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_LIMIT  = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic [2:0] status,
    output logic [8:0] position,
    output logic [1:0] bracket_kind
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int IDX_W  = $clog2(LINE_LIMIT);

    logic                 s1_valid_reg;
    logic [7:0]           s1_char_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    bbc_pkg::kind_t       top_reg, top_next;
    bbc_pkg::status_t     err_status_reg, err_status_next;
    logic [IDX_W-1:0]     err_pos_reg, err_pos_next;
    bbc_pkg::kind_t       err_kind_reg, err_kind_next;
    logic                 out_valid_reg, out_valid_next;
    bbc_pkg::status_t     out_status_reg, out_status_next;
    logic [8:0]           out_pos_reg, out_pos_next;
    bbc_pkg::kind_t       out_kind_reg, out_kind_next;

    logic                 s1_nl;
    logic                 s1_go;
    logic                 char_take;
    bbc_pkg::bracket_t    op;
    bbc_pkg::bracket_t    cl;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    bbc_pkg::kind_t       wr_data;
    logic [CNT_W-1:0]     below_idx;
    logic [ADDR_W-1:0]    rd_addr;
    bbc_pkg::kind_t       below_kind;
    logic [IDX_W-1:0]     pos_sel;

    assign s1_nl      = (s1_char_reg == bbc_pkg::CH_NEWLINE);
    assign s1_go      = s1_valid_reg && (!s1_nl || !out_valid_reg || !verdict_stall);
    assign char_stall = s1_valid_reg && !s1_go;
    assign char_take  = char_valid && !char_stall;
    assign op         = bbc_pkg::opener_decode(s1_char_reg);
    assign cl         = bbc_pkg::closer_decode(s1_char_reg);

    // entry just below the next top is prefetched every cycle
    assign below_idx = (count_next >= CNT_W'(2)) ? (count_next - CNT_W'(2)) : '0;
    assign rd_addr   = below_idx[ADDR_W-1:0];

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (below_kind)
    );

    always_comb
    begin
        count_next      = count_reg;
        index_next      = index_reg;
        top_next        = top_reg;
        err_status_next = err_status_reg;
        err_pos_next    = err_pos_reg;
        err_kind_next   = err_kind_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_data         = op.kind;
        pos_sel         = index_reg;

        out_valid_next  = out_valid_reg && verdict_stall;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_kind_next   = out_kind_reg;

        if (s1_go)
        begin
            if (s1_nl)
            begin
                out_valid_next  = 1'b1;
                out_status_next = bbc_pkg::ST_BALANCED;
                out_kind_next   = bbc_pkg::KIND_PAREN;
                pos_sel         = '0;
                if (err_status_reg != bbc_pkg::ST_BALANCED)
                begin
                    out_status_next = err_status_reg;
                    out_kind_next   = err_kind_reg;
                    pos_sel         = err_pos_reg;
                end
                else if (count_reg != '0)
                begin
                    out_status_next = bbc_pkg::ST_MISS_CLOSE;
                    out_kind_next   = top_reg;
                    pos_sel         = index_reg;
                end
                if (32'(pos_sel) > 32'(bbc_pkg::POS_CAP))
                    out_pos_next = bbc_pkg::POS_CAP;
                else
                    out_pos_next = 9'(pos_sel);

                count_next      = '0;
                index_next      = '0;
                err_status_next = bbc_pkg::ST_BALANCED;
                err_pos_next    = '0;
                err_kind_next   = bbc_pkg::KIND_PAREN;
            end
            else
            begin
                if (err_status_reg == bbc_pkg::ST_BALANCED)
                begin
                    if (op.hit)
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            err_status_next = bbc_pkg::ST_OVERFLOW;
                            err_pos_next    = index_reg;
                            err_kind_next   = op.kind;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            top_next   = op.kind;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (cl.hit)
                    begin
                        if (count_reg == '0)
                        begin
                            err_status_next = bbc_pkg::ST_MISS_OPEN;
                            err_pos_next    = index_reg;
                            err_kind_next   = cl.kind;
                        end
                        else if (top_reg == cl.kind)
                        begin
                            top_next   = below_kind;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            err_status_next = bbc_pkg::ST_WRONG_CLOSE;
                            err_pos_next    = index_reg;
                            err_kind_next   = top_reg;
                        end
                    end
                end
                if (index_reg != IDX_W'(LINE_LIMIT - 1))
                    index_next = index_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            count_reg      <= '0;
            index_reg      <= '0;
            err_status_reg <= bbc_pkg::ST_BALANCED;
            err_pos_reg    <= '0;
            err_kind_reg   <= bbc_pkg::KIND_PAREN;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (char_take)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            count_reg      <= count_next;
            index_reg      <= index_next;
            err_status_reg <= err_status_next;
            err_pos_reg    <= err_pos_next;
            err_kind_reg   <= err_kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_take)
            s1_char_reg <= char_code;
        top_reg        <= top_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_kind_reg   <= out_kind_next;
    end

    assign verdict_valid = out_valid_reg;
    assign status        = out_status_reg;
    assign position      = out_pos_reg;
    assign bracket_kind  = out_kind_reg;

endmodule

@@ design/bbc_ram.sv @@
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bbc_checker.sv @@
`timescale 1ns / 1ps

module bbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_stall,
    input logic [7:0] char_code,
    input logic       verdict_valid,
    input logic       verdict_stall,
    input logic [2:0] status,
    input logic [8:0] position,
    input logic [1:0] bracket_kind
);

    // status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (status <= bbc_pkg::ST_OVERFLOW))
        else $error("verdict status out of range");

    // a balanced line reports no position and no kind
    a_balanced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && status == bbc_pkg::ST_BALANCED)
            |-> (position == '0 && bracket_kind == bbc_pkg::KIND_PAREN))
        else $error("balanced verdict with nonzero fields");

    // an open bracket left over means at least one byte preceded the newline
    a_miss_close_len: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && status == bbc_pkg::ST_MISS_CLOSE) |-> (position != '0))
        else $error("missing closing verdict on empty line");

    // stalled verdict holds
    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && verdict_stall) |=>
            (verdict_valid && $stable(status) && $stable(position)
             && $stable(bracket_kind)))
        else $error("stalled verdict changed");

    // stalled input item holds
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_stall) |=> (char_valid && $stable(char_code)))
        else $error("stalled input item changed");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .status        (status),
    .position      (position),
    .bracket_kind  (bracket_kind)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH      = 64;
    localparam int IDX_LAST   = 511;
    localparam int RAND_ITEMS = 1350;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;

    localparam logic [7:0] OPEN_CH [4] = '{bbc_pkg::CH_PAREN_L, bbc_pkg::CH_BRACE_L,
                                           bbc_pkg::CH_SQUARE_L, bbc_pkg::CH_ANGLE_L};
    localparam logic [7:0] CLOSE_CH [4] = '{bbc_pkg::CH_PAREN_R, bbc_pkg::CH_BRACE_R,
                                            bbc_pkg::CH_SQUARE_R, bbc_pkg::CH_ANGLE_R};

    typedef struct packed {
        bbc_pkg::status_t status;
        logic [8:0]       position;
        bbc_pkg::kind_t   kind;
    } verdict_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       char_valid    = 1'b0;
    logic       char_stall;
    logic [7:0] char_code     = 8'h00;
    logic       verdict_valid;
    logic       verdict_stall = 1'b0;
    logic [2:0] status;
    logic [8:0] position;
    logic [1:0] bracket_kind;

    logic [7:0] char_plan [$];
    logic [7:0] line_buf [$];
    int         open_kinds [$];
    verdict_t   verdicts_due [$];

    // line tracker state
    bbc_pkg::kind_t   kind_stk [DEPTH];
    int               stk_cnt;
    int               line_idx;
    bbc_pkg::status_t err_st;
    logic [8:0]       err_pos;
    bbc_pkg::kind_t   err_kind;

    int errors;
    int verdicts_seen;
    int idle_cycles;
    int cyc = 0;

    bracket_balance_checker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .verdict_valid(verdict_valid),
        .verdict_stall(verdict_stall),
        .status       (status),
        .position     (position),
        .bracket_kind (bracket_kind)
    );

    always #5 clk = ~clk;

    function automatic int opener_of(logic [7:0] c);
        case (c)
            bbc_pkg::CH_PAREN_L:  return bbc_pkg::KIND_PAREN;
            bbc_pkg::CH_BRACE_L:  return bbc_pkg::KIND_BRACE;
            bbc_pkg::CH_SQUARE_L: return bbc_pkg::KIND_SQUARE;
            bbc_pkg::CH_ANGLE_L:  return bbc_pkg::KIND_ANGLE;
            default:              return -1;
        endcase
    endfunction

    function automatic int closer_of(logic [7:0] c);
        case (c)
            bbc_pkg::CH_PAREN_R:  return bbc_pkg::KIND_PAREN;
            bbc_pkg::CH_BRACE_R:  return bbc_pkg::KIND_BRACE;
            bbc_pkg::CH_SQUARE_R: return bbc_pkg::KIND_SQUARE;
            bbc_pkg::CH_ANGLE_R:  return bbc_pkg::KIND_ANGLE;
            default:              return -1;
        endcase
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == bbc_pkg::CH_NEWLINE || opener_of(c) >= 0 || closer_of(c) >= 0);
        return c;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_error(input bbc_pkg::status_t st, input bbc_pkg::kind_t k);
        err_st   = st;
        err_pos  = 9'(line_idx);
        err_kind = k;
    endtask

    task automatic clear_line();
        stk_cnt  = 0;
        line_idx = 0;
        err_st   = bbc_pkg::ST_BALANCED;
        err_pos  = '0;
        err_kind = bbc_pkg::KIND_PAREN;
    endtask

    task automatic track_byte(input logic [7:0] c);
        verdict_t v;
        int       ok;
        int       ck;
        if (c == bbc_pkg::CH_NEWLINE)
        begin
            v.status   = bbc_pkg::ST_BALANCED;
            v.position = '0;
            v.kind     = bbc_pkg::KIND_PAREN;
            if (err_st != bbc_pkg::ST_BALANCED)
            begin
                v.status   = err_st;
                v.position = err_pos;
                v.kind     = err_kind;
            end
            else if (stk_cnt != 0)
            begin
                v.status   = bbc_pkg::ST_MISS_CLOSE;
                v.position = 9'(line_idx);
                v.kind     = kind_stk[stk_cnt - 1];
            end
            verdicts_due.push_back(v);
            clear_line();
        end
        else
        begin
            if (err_st == bbc_pkg::ST_BALANCED)
            begin
                ok = opener_of(c);
                ck = closer_of(c);
                if (ok >= 0)
                begin
                    if (stk_cnt >= DEPTH)
                        note_error(bbc_pkg::ST_OVERFLOW, bbc_pkg::kind_t'(ok));
                    else
                    begin
                        kind_stk[stk_cnt] = bbc_pkg::kind_t'(ok);
                        stk_cnt++;
                    end
                end
                else if (ck >= 0)
                begin
                    if (stk_cnt == 0)
                        note_error(bbc_pkg::ST_MISS_OPEN, bbc_pkg::kind_t'(ck));
                    else if (kind_stk[stk_cnt - 1] == bbc_pkg::kind_t'(ck))
                        stk_cnt--;
                    else
                        note_error(bbc_pkg::ST_WRONG_CLOSE, kind_stk[stk_cnt - 1]);
                end
            end
            if (line_idx < IDX_LAST)
                line_idx++;
        end
    endtask

    task automatic plan_line();
        foreach (line_buf[j])
            char_plan.push_back(line_buf[j]);
        char_plan.push_back(bbc_pkg::CH_NEWLINE);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        int gap_left;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_code  <= 8'h00;
            gap_left = 0;
            clear_line();
        end
        else
        begin
            if (char_valid && !char_stall)
                track_byte(char_code);
            if (!char_valid || !char_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    char_valid <= 1'b0;
                end
                else if (char_plan.size() > 0)
                begin
                    char_valid <= 1'b1;
                    char_code  <= char_plan.pop_front();
                    gap_left = (cyc[8:7] == 2'b00) ? 0 : draw_gap();
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // receiver, with two long hold-offs to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        int stall_left;
        int hold_left;
        int hold_stage;
        if (!rst_n)
        begin
            verdict_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_stage = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            verdict_stall <= 1'b1;
        end
        else if ((hold_stage == 0 && verdicts_seen >= 15) ||
                 (hold_stage == 1 && verdicts_seen >= 60))
        begin
            hold_stage++;
            hold_left = HOLD_LEN;
            verdict_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            verdict_stall <= 1'b1;
        end
        else
        begin
            verdict_stall <= 1'b0;
            stall_left = (cyc[9:8] == 2'b01) ? 0 : draw_gap();
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && verdict_valid && !verdict_stall)
        begin
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict: expected none, %s %0d pos %0d kind %0d",
                         $time, "actual status", status, position, bracket_kind);
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    errors++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    errors++;
                end
                if (bracket_kind !== want.kind)
                begin
                    $display("%0t: bracket_kind expected %0d actual %0d",
                             $time, want.kind, bracket_kind);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if ((char_valid && !char_stall) || (verdict_valid && !verdict_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int  rand_cnt;
        int  r;
        int  len;
        int  n;
        int  pick;
        int  k;
        bit  long_done;
        errors        = 0;
        verdicts_seen = 0;
        idle_cycles   = 0;
        rand_cnt      = 0;
        long_done     = 0;

        // directed lines
        line_buf = {};
        plan_line();
        line_buf = {8'h00, bbc_pkg::CH_PAREN_L, 8'hFF, bbc_pkg::CH_PAREN_R};
        plan_line();
        line_buf = {bbc_pkg::CH_BRACE_L, bbc_pkg::CH_SQUARE_L,
                    bbc_pkg::CH_SQUARE_R, bbc_pkg::CH_BRACE_R};
        plan_line();
        line_buf = {bbc_pkg::CH_BRACE_R};
        plan_line();
        line_buf = {bbc_pkg::CH_SQUARE_L, bbc_pkg::CH_ANGLE_R};
        plan_line();
        line_buf = {bbc_pkg::CH_ANGLE_L, bbc_pkg::CH_PAREN_R, 8'h78};
        plan_line();
        line_buf = {bbc_pkg::CH_BRACE_L, bbc_pkg::CH_SQUARE_L};
        plan_line();
        line_buf = {bbc_pkg::CH_SQUARE_R, bbc_pkg::CH_PAREN_R};
        plan_line();

        while (rand_cnt < RAND_ITEMS)
        begin
            line_buf = {};
            if (!long_done && rand_cnt > RAND_ITEMS / 2)
            begin
                // one line past the index limit, exercises saturation
                long_done = 1;
                line_buf.push_back(bbc_pkg::CH_PAREN_L);
                len = $urandom_range(515, 530);
                for (int i = 0; i < len; i++)
                    line_buf.push_back(filler_byte());
                r = $urandom_range(0, 2);
                if (r == 0)
                    line_buf.push_back(bbc_pkg::CH_PAREN_R);
                else if (r == 1)
                    line_buf.push_back(bbc_pkg::CH_SQUARE_R);
                plan_line();
                rand_cnt += line_buf.size() + 1;
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = $urandom_range(0, 24);
                open_kinds = {};
                for (int i = 0; i < len; i++)
                begin
                    n = $urandom_range(0, 9);
                    if (n < 4)
                    begin
                        k = $urandom_range(0, 3);
                        open_kinds.push_back(k);
                        line_buf.push_back(OPEN_CH[k]);
                    end
                    else if (n < 7 && open_kinds.size() > 0)
                        line_buf.push_back(CLOSE_CH[open_kinds.pop_back()]);
                    else
                        line_buf.push_back(filler_byte());
                end
                while (open_kinds.size() > 0)
                    line_buf.push_back(CLOSE_CH[open_kinds.pop_back()]);
                case ($urandom_range(0, 3))
                    1:
                    begin
                        n = $urandom_range(1, 3);
                        while (n > 0 && line_buf.size() > 0 &&
                               closer_of(line_buf[line_buf.size() - 1]) >= 0)
                        begin
                            void'(line_buf.pop_back());
                            n--;
                        end
                    end
                    2:
                    begin
                        n = 0;
                        foreach (line_buf[j])
                            if (closer_of(line_buf[j]) >= 0)
                                n++;
                        if (n > 0)
                        begin
                            pick = $urandom_range(0, n - 1);
                            n = 0;
                            foreach (line_buf[j])
                                if (closer_of(line_buf[j]) >= 0)
                                begin
                                    if (n == pick)
                                        line_buf[j] = CLOSE_CH[(closer_of(line_buf[j]) +
                                                     $urandom_range(1, 3)) % 4];
                                    n++;
                                end
                        end
                    end
                    3:
                        line_buf.insert($urandom_range(0, line_buf.size()),
                                        CLOSE_CH[$urandom_range(0, 3)]);
                    default:
                        ;
                endcase
            end
            else if (r < 85)
            begin
                len = $urandom_range(0, 20);
                for (int i = 0; i < len; i++)
                    if ($urandom_range(0, 1))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                    else if ($urandom_range(0, 1))
                        line_buf.push_back(OPEN_CH[$urandom_range(0, 3)]);
                    else
                        line_buf.push_back(CLOSE_CH[$urandom_range(0, 3)]);
            end
            else if (r < 95)
            begin
                // around the stack depth
                len = $urandom_range(DEPTH - 4, DEPTH + 4);
                for (int i = 0; i < len; i++)
                    line_buf.push_back(OPEN_CH[$urandom_range(0, 3)]);
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    line_buf.push_back($urandom_range(0, 1) ? filler_byte() :
                                       CLOSE_CH[$urandom_range(0, 3)]);
            end
            plan_line();
            rand_cnt += line_buf.size() + 1;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_plan.size() != 0 || char_valid)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0 && verdicts_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ bracket_balance_checker.f @@
design/bbc_pkg.sv
design/bbc_ram.sv
design/bracket_balance_checker.sv
design/bbc_checker.sv
verif/tb_top.sv
